// ===== hdl/lfd_pkg.sv =====
package lfd_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] CHECK_POS = 4'd5;
  localparam logic [3:0] LAST_POS  = 4'd12;

  localparam logic [7:0] END_A     = 8'h32;
  localparam logic [7:0] END_B     = 8'h37;
  localparam logic [7:0] END_TAIL  = 8'h0E;
  localparam logic [7:0] FIXED_KEY = 8'd10;
  localparam logic [7:0] KEY_LIMIT = 8'd50;
  localparam logic [4:0] SPEED_BASE = 5'd10;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_CHK_FAIL = 2'd1;
  localparam logic [1:0] ST_BAD_END  = 2'd2;

  // one completed frame as the front hands it on
  typedef struct packed {
    logic       end_ok;
    logic [7:0] xsum;
    logic [7:0] chk;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b4;
    logic [7:0] b7;
  } frame_rec_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic [5:0] learned_key;
    logic [3:0] max_current;
    logic [7:0] p5_value;
    logic       p4_flag;
    logic [2:0] wheel_magnets;
    logic       power_assist_mode;
    logic [5:0] max_speed;
    logic [4:0] wheel_size;
    logic [7:0] motor_characteristic;
    logic       light_on;
    logic [2:0] pas_level;
    logic [1:0] status;
  } result_t;

endpackage

// ===== hdl/lcd_frame_decoder_xor_check_core.sv =====
// channel   dir  handshake                 payload
// s_axis    in   s_tvalid / s_tready       s_tdata[7:0]  rx_byte
// m_axis    out  m_tvalid / m_tready       m_tdata[47:0] decoded frame result
//
// one byte is accepted per cycle while s_tready is high; results are queued, then registered
// front counts and checks bytes; back judges frames one per cycle from a 2-deep queue while
// the output is free; only the last byte of a frame stalls, and only while the queue is full
// rst clears the byte counter, running xor, queue and learned key; a new frame starts at byte 0
module lcd_frame_decoder_xor_check_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, pas_level, light_on, motor_characteristic, wheel_size, max_speed,
  // power_assist_mode, wheel_magnets, p4_flag, p5_value, max_current, learned_key
  output logic [47:0] m_tdata
);
  import lfd_pkg::*;

  logic       push, pop, q_full, q_valid;
  frame_rec_t wr_rec, rd_rec;
  result_t    res;

  lfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .push     (push),
    .rec      (wr_rec),
    .q_full   (q_full)
  );

  lfd_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .pop    (pop),
    .valid  (q_valid),
    .rd_rec (rd_rec)
  );

  lfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_rec     (rd_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = res;

endmodule

// ===== hdl/lfd_front.sv =====
module lfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              push,
  output lfd_pkg::frame_rec_t rec,
  input  logic              q_full
);
  import lfd_pkg::*;

  logic [3:0] byte_count;
  logic [7:0] running_xor;
  logic [7:0] b0, b1, b2, b3, b4, chk, b7, b11;
  logic       accept;
  logic       last;
  logic [7:0] xsum;

  assign last     = (byte_count == LAST_POS);
  assign in_ready = !q_full || !last;
  assign accept   = in_valid && in_ready;
  assign push     = accept && last;
  assign xsum     = running_xor ^ in_byte;

  always_comb begin
    rec.end_ok = ((b11 == END_A) || (b11 == END_B)) && (in_byte == END_TAIL);
    rec.xsum   = xsum;
    rec.chk    = chk;
    rec.b0     = b0;
    rec.b1     = b1;
    rec.b2     = b2;
    rec.b3     = b3;
    rec.b4     = b4;
    rec.b7     = b7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_xor <= '0;
    end else if (accept) begin
      if (last) begin
        byte_count  <= '0;
        running_xor <= '0;
      end else begin
        byte_count <= byte_count + 4'd1;
        if (byte_count != CHECK_POS) begin
          running_xor <= xsum;
        end
      end
    end
  end

  // frame byte capture, only the bytes the decode needs
  always_ff @(posedge clk) begin
    if (accept) begin
      unique case (byte_count)
        4'd0:    b0  <= in_byte;
        4'd1:    b1  <= in_byte;
        4'd2:    b2  <= in_byte;
        4'd3:    b3  <= in_byte;
        4'd4:    b4  <= in_byte;
        4'd5:    chk <= in_byte;
        4'd7:    b7  <= in_byte;
        4'd11:   b11 <= in_byte;
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count <= LAST_POS)
    else $error("byte counter out of range");

  a_wrap: assert property (@(posedge clk) disable iff (rst)
    push |=> (byte_count == 4'd0) && (running_xor == 8'd0))
    else $error("frame state not cleared after last byte");

endmodule

// ===== hdl/lfd_queue.sv =====
module lfd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  lfd_pkg::frame_rec_t wr_rec,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output lfd_pkg::frame_rec_t rd_rec
);
  import lfd_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  frame_rec_t    mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] level;

  assign full   = (level == FULL_CNT);
  assign valid  = (level != '0);
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        level <= level + CW'(1);
      end else if (pop && !push) begin
        level <= level - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !valid))
    else $error("pop from empty queue");

endmodule

// ===== hdl/lfd_back.sv =====
module lfd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  lfd_pkg::frame_rec_t q_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output lfd_pkg::result_t  out_res
);
  import lfd_pkg::*;

  logic [5:0] key_store;
  logic [5:0] key_next;
  logic [7:0] cand;
  logic       match;
  result_t    res_next;

  assign pop   = q_valid && (!out_valid || out_ready);
  assign cand  = q_rec.xsum ^ q_rec.chk;
  assign match = ((q_rec.xsum ^ FIXED_KEY) == q_rec.chk) ||
                 ((q_rec.xsum ^ {2'b00, key_store}) == q_rec.chk);

  always_comb begin
    key_next = key_store;
    res_next = '0;
    if (!q_rec.end_ok) begin
      res_next.status = ST_BAD_END;
    end else if (match) begin
      res_next.status               = ST_VALID;
      res_next.pas_level            = q_rec.b1[2:0];
      res_next.light_on             = q_rec.b1[7];
      res_next.motor_characteristic = q_rec.b3;
      res_next.wheel_size           = {q_rec.b2[2:0], q_rec.b4[7:6]};
      res_next.max_speed            = ({1'b0, SPEED_BASE} + {1'b0, q_rec.b2[7:3]}) |
                                      {q_rec.b4[5], 5'b0};
      res_next.power_assist_mode    = q_rec.b4[3];
      res_next.wheel_magnets        = q_rec.b4[2:0];
      res_next.p4_flag              = q_rec.b4[4];
      res_next.p5_value             = q_rec.b0;
      res_next.max_current          = q_rec.b7[3:0];
    end else begin
      res_next.status = ST_CHK_FAIL;
      if (cand <= KEY_LIMIT) begin
        key_next = cand[5:0];
      end
    end
    res_next.learned_key = key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      key_store <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        key_store <= key_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= res_next;
    end
  end

  a_key_limit: assert property (@(posedge clk) disable iff (rst)
    {2'b00, key_store} <= KEY_LIMIT)
    else $error("learned key above limit");

  a_key_only_on_fail: assert property (@(posedge clk) disable iff (rst)
    (key_store != $past(key_store)) |-> $past(pop) &&
      (out_res.status == ST_CHK_FAIL))
    else $error("key changed outside a checksum failure");

endmodule

// ===== tb/lcd_frame_decoder_xor_check_core_tb.sv =====
`timescale 1ns / 100ps

module lcd_frame_decoder_xor_check_core_tb;
  import lfd_pkg::*;

  localparam int FRAME_LEN   = 13;
  localparam int STALL_LIMIT = 4000;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  int tx_idle_pct = 28;
  int rx_idle_pct = 55;
  int errors = 0;
  int stuck_cycles = 0;

  // decoder mirror
  frame_t     frame_buf = '0;
  logic [3:0] byte_pos = '0;
  logic [7:0] xor_acc = '0;
  logic [5:0] key_reg = '0;
  result_t    frames_due[$];

  int n_bytes = 0;
  int n_valid = 0;
  int n_chk_fail = 0;
  int n_bad_end = 0;
  int n_learned = 0;

  lcd_frame_decoder_xor_check_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic absorb_byte(input logic [7:0] b);
    result_t    r;
    logic [7:0] cand;
    logic       end_ok;
    n_bytes++;
    frame_buf[byte_pos] = b;
    if (byte_pos != CHECK_POS) xor_acc = xor_acc ^ b;
    if (byte_pos == LAST_POS) begin
      r = '0;
      end_ok = (frame_buf[11] == END_A || frame_buf[11] == END_B) &&
               frame_buf[12] == END_TAIL;
      if (!end_ok) begin
        r.status = ST_BAD_END;
        n_bad_end++;
      end else if ((xor_acc ^ FIXED_KEY) == frame_buf[CHECK_POS] ||
                   (xor_acc ^ {2'b00, key_reg}) == frame_buf[CHECK_POS]) begin
        r.status               = ST_VALID;
        r.pas_level            = frame_buf[1][2:0];
        r.light_on             = frame_buf[1][7];
        r.motor_characteristic = frame_buf[3];
        r.wheel_size           = {frame_buf[2][2:0], frame_buf[4][7:6]};
        r.max_speed            = ({1'b0, SPEED_BASE} + {1'b0, frame_buf[2][7:3]}) |
                                 {frame_buf[4][5], 5'b00000};
        r.power_assist_mode    = frame_buf[4][3];
        r.wheel_magnets        = frame_buf[4][2:0];
        r.p4_flag              = frame_buf[4][4];
        r.p5_value             = frame_buf[0];
        r.max_current          = frame_buf[7][3:0];
        n_valid++;
      end else begin
        r.status = ST_CHK_FAIL;
        cand = xor_acc ^ frame_buf[CHECK_POS];
        if (cand <= KEY_LIMIT) begin
          key_reg = cand[5:0];
          n_learned++;
        end
        n_chk_fail++;
      end
      r.learned_key = key_reg;
      frames_due.push_back(r);
      byte_pos = '0;
      xor_acc  = '0;
    end else begin
      byte_pos = byte_pos + 4'd1;
    end
  endtask

  task automatic cmp_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(input result_t got, input result_t want);
    cmp_field("status", want.status, got.status);
    cmp_field("pas_level", want.pas_level, got.pas_level);
    cmp_field("light_on", want.light_on, got.light_on);
    cmp_field("motor_characteristic", want.motor_characteristic, got.motor_characteristic);
    cmp_field("wheel_size", want.wheel_size, got.wheel_size);
    cmp_field("max_speed", want.max_speed, got.max_speed);
    cmp_field("power_assist_mode", want.power_assist_mode, got.power_assist_mode);
    cmp_field("wheel_magnets", want.wheel_magnets, got.wheel_magnets);
    cmp_field("p4_flag", want.p4_flag, got.p4_flag);
    cmp_field("p5_value", want.p5_value, got.p5_value);
    cmp_field("max_current", want.max_current, got.max_current);
    cmp_field("learned_key", want.learned_key, got.learned_key);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) absorb_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (frames_due.size() == 0) begin
          $error("result with nothing pending: m_tdata 0x%h", m_tdata);
          errors++;
        end else begin
          check_result(result_t'(m_tdata), frames_due.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame(input frame_t f);
    for (int j = 0; j < FRAME_LEN; j++) send_byte(f[j]);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    for (int j = 0; j < FRAME_LEN; j++) f[j] = 8'($urandom_range(255));
    f[11] = $urandom_range(1) ? END_A : END_B;
    f[12] = END_TAIL;
    return f;
  endfunction

  function automatic frame_t seal_frame(input frame_t f, input logic [7:0] key);
    logic [7:0] x;
    x = '0;
    for (int j = 0; j < FRAME_LEN; j++)
      if (j != CHECK_POS) x = x ^ f[j];
    f[CHECK_POS] = x ^ key;
    return f;
  endfunction

  function automatic frame_t break_end(input frame_t f);
    if ($urandom_range(1)) begin
      do f[11] = 8'($urandom_range(255)); while (f[11] == END_A || f[11] == END_B);
    end else begin
      do f[12] = 8'($urandom_range(255)); while (f[12] == END_TAIL);
    end
    return f;
  endfunction

  task automatic test_directed();
    frame_t f;
    tx_idle_pct = 28;
    rx_idle_pct = 55;
    // field extremes, both end marker values
    f = '0;
    f[11] = END_A;
    f[12] = END_TAIL;
    send_frame(seal_frame(f, FIXED_KEY));
    f = '1;
    f[11] = END_B;
    f[12] = END_TAIL;
    send_frame(seal_frame(f, FIXED_KEY));
    // bad end marker in either position
    f = seal_frame(random_frame(), FIXED_KEY);
    f[11] = 8'h33;
    send_frame(f);
    f = seal_frame(random_frame(), FIXED_KEY);
    f[12] = 8'h0F;
    send_frame(f);
    // key learning at the limit, then a frame passing on the learned key
    send_frame(seal_frame(random_frame(), KEY_LIMIT));
    send_frame(seal_frame(random_frame(), KEY_LIMIT));
    // candidates above the limit leave the key alone
    send_frame(seal_frame(random_frame(), KEY_LIMIT + 8'd1));
    send_frame(seal_frame(random_frame(), 8'hFF));
    // learn zero, then pass on it
    send_frame(seal_frame(random_frame(), 8'd0));
    send_frame(seal_frame(random_frame(), 8'd0));
    wait_for_drain();
  endtask

  task automatic test_random_frames(input int tx_pct, input int rx_pct, input int n_frames);
    frame_t f;
    int     kind;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_frames; i++) begin
      kind = $urandom_range(99);
      f = random_frame();
      if (kind < 55) f = seal_frame(f, FIXED_KEY);
      else if (kind < 70) f = seal_frame(f, {2'b00, key_reg});
      else if (kind < 82) f = seal_frame(f, 8'($urandom_range(63)));
      else if (kind < 92) f = break_end(seal_frame(f, FIXED_KEY));
      else for (int j = 0; j < FRAME_LEN; j++) f[j] = 8'($urandom_range(255));
      send_frame(f);
      if ($urandom_range(19) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_frames(28, 55, 19);
    test_random_frames(55, 28, 19);
    test_random_frames(0, 0, 19);
    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes: %0d valid frames, %0d checksum mismatches, %0d bad end markers",
             n_bytes, n_valid, n_chk_fail, n_bad_end);
    $display("key learned %0d times, final key %0d, with idle mixes 28/55, 55/28 and none",
             n_learned, key_reg);
    if (errors == 0 && frames_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lfd_pkg.sv
hdl/lfd_front.sv
hdl/lfd_queue.sv
hdl/lfd_back.sv
hdl/lcd_frame_decoder_xor_check_core.sv
tb/lcd_frame_decoder_xor_check_core_tb.sv
